// File: src/acds_pkg.sv
// ----------------------------------------------------------------------------
// acds_pkg
// Shared constants and codes for the accelerator core dispatch selector.
// ----------------------------------------------------------------------------
package acds_pkg;

  localparam int NUM_CORES  = 3;   // 1 .. 3
  localparam int LOAD_WIDTH = 16;  // 4 .. 16

  // index / pointer width, at least one bit
  localparam int IDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  localparam logic [7:0] ALL_MASK = 8'((9'd1 << NUM_CORES) - 9'd1);

  typedef logic [LOAD_WIDTH-1:0] load_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [1:0] {
    REQ_SELECT = 2'd0,
    REQ_START  = 2'd1,
    REQ_END    = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STRAT_ROUND_ROBIN  = 2'd0,
    STRAT_LEAST_LOADED = 2'd1,
    STRAT_CORE_ZERO    = 2'd2,
    STRAT_ALL_CORES    = 2'd3
  } strat_t;

endpackage

// File: src/accelerator_core_dispatch_selector_unit.sv
// ----------------------------------------------------------------------------
// accelerator_core_dispatch_selector_unit
// Picks the core for the next task and tracks per-core active task counts.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | req_type, target_core
//  out     | out_valid / out_ready | core_mask, active_count, total_selected,
//          |                       | index_valid
//  cfg     | cfg_we                | cfg_wdata (strategy)
//
//  One item per cycle while the output is not stalled: the result is registered in the
//  output register at the edge that accepts the item; state is updated at the same edge.
//  in_ready is high whenever the output register is empty or being drained.
//  A stalled output holds its item and blocks further input.
//  Synchronous reset clears counters, pointer, select total and strategy.
module accelerator_core_dispatch_selector_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [2:0]  target_core,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  core_mask,
  output logic [15:0] active_count,
  output logic [63:0] total_selected,
  output logic        index_valid
);
  import acds_pkg::*;

  strat_t       strategy;
  load_t        core_load [NUM_CORES];
  idx_t         rotate_pointer;
  logic [63:0]  select_total;

  logic         accept;
  req_t         req;
  logic         idx_ok;
  idx_t         idx;
  idx_t         best_idx;
  load_t        best_val;
  idx_t         pick;
  logic [7:0]   mask_full;
  logic [31:0]  count_ext;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign req      = req_t'(req_type);
  assign idx_ok   = {1'b0, target_core} < 4'(NUM_CORES);
  assign idx      = target_core[IDX_W-1:0];

  // least loaded, lowest index wins ties
  always_comb begin
    best_idx = '0;
    best_val = core_load[0];
    for (int i = 1; i < NUM_CORES; i++) begin
      if (core_load[i] < best_val) begin
        best_idx = IDX_W'(i);
        best_val = core_load[i];
      end
    end
  end

  always_comb begin
    pick      = '0;
    mask_full = '0;
    case (strategy)
      STRAT_ROUND_ROBIN: begin
        pick      = rotate_pointer;
        mask_full = 8'(1) << pick;
      end
      STRAT_LEAST_LOADED: begin
        pick      = best_idx;
        mask_full = 8'(1) << pick;
      end
      STRAT_CORE_ZERO: mask_full = 8'd1;
      STRAT_ALL_CORES: mask_full = ALL_MASK;
      default:         mask_full = '0;
    endcase
  end

  assign count_ext = 32'(core_load[idx]);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy       <= STRAT_ROUND_ROBIN;
      rotate_pointer <= '0;
      select_total   <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < NUM_CORES; i++) begin
        core_load[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        strategy <= strat_t'(cfg_wdata);
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept && req == REQ_SELECT) begin
        select_total <= select_total + 64'd1;
        if (strategy == STRAT_ROUND_ROBIN) begin
          rotate_pointer <= (rotate_pointer == IDX_W'(NUM_CORES - 1)) ? '0
                                                                      : rotate_pointer + 1'b1;
        end
      end
      for (int i = 0; i < NUM_CORES; i++) begin
        if (accept && idx_ok && idx == IDX_W'(i)) begin
          if (req == REQ_START && core_load[i] != '1) begin
            core_load[i] <= core_load[i] + 1'b1;
          end else if (req == REQ_END && core_load[i] != '0) begin
            core_load[i] <= core_load[i] - 1'b1;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      if (req == REQ_SELECT) begin
        core_mask      <= mask_full[2:0];
        active_count   <= '0;
        total_selected <= select_total + 64'd1;
        index_valid    <= 1'b0;
      end else begin
        core_mask      <= '0;
        active_count   <= (idx_ok && req == REQ_QUERY) ? count_ext[15:0] : '0;
        total_selected <= select_total;
        index_valid    <= idx_ok;
      end
    end
  end

`ifndef SYNTHESIS
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    accept && req == REQ_SELECT |=> select_total == $past(select_total) + 64'd1)
    else $error("select total did not step on a select item");

  a_total_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> total_selected == select_total)
    else $error("reported total differs from running total");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, rotate_pointer} < (IDX_W + 1)'(NUM_CORES))
    else $error("round-robin pointer out of range");

  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    accept && req != REQ_SELECT && !idx_ok |=> !index_valid && active_count == '0)
    else $error("invalid index not flagged");

  a_mask_zero: assert property (@(posedge clk) disable iff (rst)
    accept && req != REQ_SELECT |=> core_mask == '0)
    else $error("core mask set on a non-select item");
`endif

endmodule

// File: dv/tb_accelerator_core_dispatch_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accelerator_core_dispatch_selector_unit
// Checks core selection under all four strategies and per-core load tracking.
// Requests go in through a stalling handshake. A local model of the load
// counters, rotation pointer and select total predicts every response, and
// each response is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_accelerator_core_dispatch_selector_unit;
  import acds_pkg::*;

  localparam int    STALL_LIMIT = 2000;
  localparam load_t LOAD_FULL   = '1;

  typedef struct packed {
    logic [2:0]  mask;
    logic [15:0] load;
    logic [63:0] total;
    logic        hit;
  } dispatch_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [2:0]  target_core;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  core_mask;
  logic [15:0] active_count;
  logic [63:0] total_selected;
  logic        index_valid;

  // model of the selector
  load_t       load_cnt [NUM_CORES];
  int          rr_ptr;
  logic [63:0] sel_count;
  strat_t      strat_model;

  dispatch_t   dispatch_answers [$];
  int          mismatches   = 0;
  int          stall_cycles = 0;
  bit          quiet        = 1'b0;

  accelerator_core_dispatch_selector_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .target_core    (target_core),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .core_mask      (core_mask),
    .active_count   (active_count),
    .total_selected (total_selected),
    .index_valid    (index_valid)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 18);
  end

  task automatic flag_mismatch(string msg);
    $display("%0t ERROR %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic dispatch_t predict_dispatch(req_t req, logic [2:0] idx);
    dispatch_t r;
    logic      hit;
    int        best;
    r   = '0;
    hit = (int'(idx) < NUM_CORES);
    if (req == REQ_SELECT) begin
      sel_count = sel_count + 64'd1;
      case (strat_model)
        STRAT_ROUND_ROBIN: begin
          r.mask = 3'(1 << rr_ptr);
          rr_ptr = (rr_ptr + 1 >= NUM_CORES) ? 0 : rr_ptr + 1;
        end
        STRAT_LEAST_LOADED: begin
          best = 0;
          for (int i = 1; i < NUM_CORES; i++) begin
            if (load_cnt[i] < load_cnt[best]) best = i;
          end
          r.mask = 3'(1 << best);
        end
        STRAT_CORE_ZERO: r.mask = 3'd1;
        default:         r.mask = ALL_MASK[2:0];
      endcase
    end else if (hit) begin
      r.hit = 1'b1;
      case (req)
        REQ_START: if (load_cnt[idx] != LOAD_FULL) load_cnt[idx] = load_cnt[idx] + 1'b1;
        REQ_END:   if (load_cnt[idx] != '0) load_cnt[idx] = load_cnt[idx] - 1'b1;
        default:   r.load = 16'(load_cnt[idx]);
      endcase
    end
    r.total = sel_count;
    return r;
  endfunction

  // response checking, then prediction of the item accepted at this edge
  always @(posedge clk) begin
    dispatch_t want;
    if (rst) begin
      foreach (load_cnt[i]) load_cnt[i] = '0;
      rr_ptr      = 0;
      sel_count   = '0;
      strat_model = STRAT_ROUND_ROBIN;
    end else begin
      if (out_valid && out_ready) begin
        if (dispatch_answers.size() == 0) begin
          flag_mismatch($sformatf("unexpected response mask=%0h count=%0d total=%0d hit=%0b",
                                  core_mask, active_count, total_selected, index_valid));
        end else begin
          want = dispatch_answers.pop_front();
          if (core_mask !== want.mask)
            flag_mismatch($sformatf("core_mask %0h, want %0h", core_mask, want.mask));
          if (active_count !== want.load)
            flag_mismatch($sformatf("active_count %0d, want %0d", active_count, want.load));
          if (total_selected !== want.total)
            flag_mismatch($sformatf("total_selected %0d, want %0d", total_selected, want.total));
          if (index_valid !== want.hit)
            flag_mismatch($sformatf("index_valid %0b, want %0b", index_valid, want.hit));
        end
      end
      if (in_valid && in_ready)
        dispatch_answers.push_back(predict_dispatch(req_t'(req_type), target_core));
      if (cfg_we) strat_model = strat_t'(cfg_wdata);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("accelerator_core_dispatch_selector_unit: mismatch");
    $finish;
  end

  // returns at the edge where the item is taken
  task automatic send_request(req_t req, logic [2:0] idx);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    target_core <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (dispatch_answers.size() != 0) @(posedge clk);
  endtask

  task automatic set_strategy(strat_t s);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_round_robin();
    set_strategy(STRAT_ROUND_ROBIN);
    repeat (4) send_request(REQ_SELECT, 3'd0);  // pointer wraps after the last core
  endtask

  task automatic test_load_tracking();
    for (int i = 0; i < 8; i++) send_request(REQ_QUERY, 3'(i));
    send_request(REQ_START, 3'd0);
    send_request(REQ_START, 3'd2);
    send_request(REQ_START, 3'd2);
    send_request(REQ_END, 3'd1);    // already empty
    send_request(REQ_END, 3'd5);    // no such core
    send_request(REQ_START, 3'd7);
    for (int i = 0; i < NUM_CORES; i++) send_request(REQ_QUERY, 3'(i));
  endtask

  task automatic test_strategies();
    settle();
    set_strategy(STRAT_LEAST_LOADED);
    send_request(REQ_SELECT, 3'd0);
    send_request(REQ_START, 3'd1);
    send_request(REQ_END, 3'd0);
    send_request(REQ_SELECT, 3'd0);  // core 0 is the least loaded
    settle();
    set_strategy(STRAT_CORE_ZERO);
    send_request(REQ_SELECT, 3'd6);
    settle();
    set_strategy(STRAT_ALL_CORES);
    send_request(REQ_SELECT, 3'd3);
  endtask

  task automatic test_random_traffic(int n_items);
    strat_t     plan [8] = '{STRAT_ROUND_ROBIN, STRAT_LEAST_LOADED, STRAT_CORE_ZERO,
                             STRAT_ALL_CORES, STRAT_LEAST_LOADED, STRAT_ROUND_ROBIN,
                             STRAT_ALL_CORES, STRAT_CORE_ZERO};
    logic [2:0] idx;
    for (int p = 0; p < 8; p++) begin
      settle();
      set_strategy(plan[p]);
      quiet = (p == 4);
      for (int k = 0; k < n_items / 8; k++) begin
        if ($urandom_range(99) < 80) idx = 3'($urandom_range(NUM_CORES - 1));
        else idx = 3'($urandom_range(7, NUM_CORES));
        send_request(req_t'($urandom_range(3)), idx);
      end
    end
    quiet = 1'b0;
  endtask

  // drive core 1 down past empty, then make sure it does not wrap
  task automatic test_counter_saturation();
    settle();
    set_strategy(STRAT_LEAST_LOADED);
    quiet = 1'b1;
    repeat (64) send_request(REQ_END, 3'd1);
    send_request(REQ_QUERY, 3'd1);
    send_request(REQ_SELECT, 3'd0);
    send_request(REQ_START, 3'd1);
    send_request(REQ_QUERY, 3'd1);
    send_request(REQ_END, 3'd1);
    send_request(REQ_END, 3'd1);
    send_request(REQ_QUERY, 3'd1);
    quiet = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    req_type    = '0;
    target_core = '0;
    out_ready   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_round_robin();
    test_load_tracking();
    test_strategies();
    test_random_traffic(1320);
    test_counter_saturation();
    settle();
    repeat (4) @(posedge clk);
    if (dispatch_answers.size() != 0)
      flag_mismatch($sformatf("%0d responses never arrived", dispatch_answers.size()));
    if (mismatches == 0) begin
      $display("accelerator_core_dispatch_selector_unit: match");
    end else begin
      $display("accelerator_core_dispatch_selector_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: accelerator_core_dispatch_selector_unit.f
src/acds_pkg.sv
src/accelerator_core_dispatch_selector_unit.sv
dv/tb_accelerator_core_dispatch_selector_unit.sv
